>>> design/ccr_pkg.sv
`default_nettype none

package ccr_pkg;

  // Console byte values that steer the line editor.
  localparam logic [7:0] CHAR_BANG = 8'h21;
  localparam logic [7:0] CHAR_CR   = 8'h0d;
  localparam logic [7:0] CHAR_LF   = 8'h0a;
  localparam logic [7:0] CHAR_DEL  = 8'h7f;
  localparam logic [7:0] CHAR_BS   = 8'h08;
  localparam logic [7:0] CHAR_A    = 8'h61;
  localparam logic [7:0] CHAR_Z    = 8'h7a;

  localparam int LETTER_W = 5;
  localparam int CODE_W   = 5;
  localparam int POS_W    = 4;

  // Longest keyword; letters past this position never affect the result.
  localparam int KW_MAX_LEN = 10;
  localparam int KW_COUNT   = 29;

  // Configuration register indexes.
  localparam logic CFG_IDX_PAIRING = 1'b0;
  localparam logic CFG_IDX_DONGLE  = 1'b1;

  // Command codes.
  localparam logic [CODE_W-1:0] CMD_UNKNOWN    = 5'd0;
  localparam logic [CODE_W-1:0] CMD_REBOOT     = 5'd1;
  localparam logic [CODE_W-1:0] CMD_BOOTLOADER = 5'd2;
  localparam logic [CODE_W-1:0] CMD_BLE        = 5'd3;
  localparam logic [CODE_W-1:0] CMD_USB        = 5'd4;
  localparam logic [CODE_W-1:0] CMD_NUKE       = 5'd5;
  localparam logic [CODE_W-1:0] CMD_FORGET     = 5'd6;
  localparam logic [CODE_W-1:0] CMD_PAIR       = 5'd7;
  localparam logic [CODE_W-1:0] CMD_UNPAIR     = 5'd8;
  localparam logic [CODE_W-1:0] CMD_SCAN       = 5'd9;
  localparam logic [CODE_W-1:0] CMD_STATUS     = 5'd10;
  localparam logic [CODE_W-1:0] CMD_CLEARHOSTS = 5'd11;
  localparam logic [CODE_W-1:0] CMD_CLEAR      = 5'd12;
  localparam logic [CODE_W-1:0] CMD_NVSCLEAR   = 5'd13;
  localparam logic [CODE_W-1:0] CMD_NVS        = 5'd14;
  localparam logic [CODE_W-1:0] CMD_ISTICK     = 5'd15;
  localparam logic [CODE_W-1:0] CMD_ISTOP      = 5'd16;
  localparam logic [CODE_W-1:0] CMD_ISTATUS    = 5'd17;
  localparam logic [CODE_W-1:0] CMD_ITYPE      = 5'd18;
  localparam logic [CODE_W-1:0] CMD_PROFILES   = 5'd19;
  localparam logic [CODE_W-1:0] CMD_DEBUG      = 5'd20;
  localparam logic [CODE_W-1:0] CMD_NODEBUG    = 5'd21;
  localparam logic [CODE_W-1:0] CMD_VERSION    = 5'd22;
  localparam logic [CODE_W-1:0] CMD_HELP       = 5'd23;

  localparam logic [1:0] GRP_BASE    = 2'd0;
  localparam logic [1:0] GRP_PAIRING = 2'd1;
  localparam logic [1:0] GRP_DONGLE  = 2'd2;

  // Keywords in priority order. Strings are right-justified in the vector.
  localparam logic [8*KW_MAX_LEN-1:0] KW_WORD [KW_COUNT] = '{
    "reboot", "reset", "boot", "flash", "dfu", "ble", "usb", "nuke", "forget",
    "pair", "unpair", "scan", "hogp", "status", "clearhosts", "clear",
    "nvsclear", "nvs", "istick", "istop", "istatus", "itype",
    "profiles", "prof", "debug", "nodebug", "version", "ver", "help"
  };

  localparam logic [POS_W-1:0] KW_LEN [KW_COUNT] = '{
    4'd6, 4'd5, 4'd4, 4'd5, 4'd3, 4'd3, 4'd3, 4'd4, 4'd6,
    4'd4, 4'd6, 4'd4, 4'd4, 4'd6, 4'd10, 4'd5,
    4'd8, 4'd3, 4'd6, 4'd5, 4'd7, 4'd5,
    4'd8, 4'd4, 4'd5, 4'd7, 4'd7, 4'd3, 4'd4
  };

  localparam logic [CODE_W-1:0] KW_CODE [KW_COUNT] = '{
    CMD_REBOOT, CMD_REBOOT, CMD_BOOTLOADER, CMD_BOOTLOADER, CMD_BOOTLOADER,
    CMD_BLE, CMD_USB, CMD_NUKE, CMD_FORGET,
    CMD_PAIR, CMD_UNPAIR, CMD_SCAN, CMD_STATUS, CMD_STATUS, CMD_CLEARHOSTS,
    CMD_CLEAR, CMD_NVSCLEAR, CMD_NVS,
    CMD_ISTICK, CMD_ISTOP, CMD_ISTATUS, CMD_ITYPE,
    CMD_PROFILES, CMD_PROFILES, CMD_DEBUG, CMD_NODEBUG,
    CMD_VERSION, CMD_VERSION, CMD_HELP
  };

  localparam logic [1:0] KW_GROUP [KW_COUNT] = '{
    GRP_BASE, GRP_BASE, GRP_BASE, GRP_BASE, GRP_BASE, GRP_BASE, GRP_BASE,
    GRP_BASE, GRP_BASE,
    GRP_PAIRING, GRP_PAIRING, GRP_PAIRING, GRP_PAIRING, GRP_PAIRING,
    GRP_PAIRING, GRP_PAIRING, GRP_PAIRING, GRP_PAIRING,
    GRP_DONGLE, GRP_DONGLE, GRP_DONGLE, GRP_DONGLE,
    GRP_BASE, GRP_BASE, GRP_BASE, GRP_BASE, GRP_BASE, GRP_BASE, GRP_BASE
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CMP,
    ST_DONE
  } state_t;

  // Character of keyword k at position pos; zero past the end of the word.
  function automatic logic [7:0] kw_char(input int k, input logic [POS_W-1:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    for (int j = 0; j < KW_MAX_LEN; j++) begin
      if (pos == POS_W'(j) && POS_W'(j) < KW_LEN[k]) begin
        ch = KW_WORD[k][(int'(KW_LEN[k]) - 1 - j) * 8 +: 8];
      end
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> design/ccr_in_if.sv
`default_nettype none

interface ccr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> design/ccr_out_if.sv
`default_nettype none

interface ccr_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] command_code;
  logic       debug_enabled;

  modport source (output valid, output command_code, output debug_enabled, input ready);
  modport sink (input valid, input command_code, input debug_enabled, output ready);
endinterface

`default_nettype wire

>>> design/console_command_recognizer_unit.sv
`default_nettype none
// A new byte is accepted every cycle while no match is running.
// A line end that carries a command starts a match that walks the first ten
// letter positions, each by a letter RAM read (FETCH) and then a compare (CMP);
// the result is registered in DONE once the output slot is free.
// Synchronous active-low reset clears the line, the debug flag and the output;
// both keyword groups come out of reset enabled. The letter RAM is not cleared.

module console_command_recognizer_unit #(
  parameter int LINE_CAP = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ccr_in_if.sink     in_chan,
  ccr_out_if.source  out_chan,
  input  wire logic  cfg_we,
  input  wire logic  cfg_index,
  input  wire logic  cfg_wdata
);

  import ccr_pkg::*;

  localparam int DEPTH  = LINE_CAP - 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LEN_W  = $clog2(LINE_CAP);

  state_t                  state_r, state_nxt;
  logic                    line_active_r;
  logic [LEN_W-1:0]        line_len_r;
  logic                    debug_r;
  logic                    pairing_en_r;
  logic                    dongle_en_r;
  logic [POS_W-1:0]        pos_r;
  logic [KW_COUNT-1:0]     alive_r;
  logic [KW_COUNT-1:0]     alive_nxt;
  logic                    out_valid_r;
  logic [CODE_W-1:0]       out_code_r;
  logic                    out_debug_r;

  logic                    in_ready;
  logic                    in_acc;
  logic                    step;
  logic                    finish;
  logic                    is_bang;
  logic                    is_eol;
  logic                    is_letter;
  logic                    is_erase;
  logic                    has_room;
  logic                    start_match;
  logic [7:0]              letter_off;
  logic                    ram_we;
  logic [LETTER_W-1:0]     ram_rdata;
  logic                    pos_in_line;
  logic [CODE_W-1:0]       sel_code;
  logic                    debug_nxt;

  // Byte classification.
  always_comb begin
    is_bang    = (in_chan.rx_byte == CHAR_BANG);
    is_eol     = (in_chan.rx_byte == CHAR_CR) || (in_chan.rx_byte == CHAR_LF);
    is_letter  = (in_chan.rx_byte >= CHAR_A) && (in_chan.rx_byte <= CHAR_Z);
    is_erase   = (in_chan.rx_byte == CHAR_DEL) || (in_chan.rx_byte == CHAR_BS);
    letter_off = in_chan.rx_byte - CHAR_A;
    has_room   = (line_len_r < LEN_W'(LINE_CAP - 1));
  end

  assign in_acc      = in_chan.valid && in_ready;
  assign start_match = in_acc && is_eol && line_active_r && (line_len_r != '0);
  assign ram_we      = in_acc && !is_bang && !is_eol && line_active_r && is_letter
                       && has_room;

  ccr_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (DEPTH)
  ) u_letters (
    .clk   (clk),
    .we    (ram_we),
    .waddr (line_len_r[ADDR_W-1:0]),
    .wdata (letter_off[LETTER_W-1:0]),
    .raddr (ADDR_W'(pos_r)),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start_match) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_CMP;
      ST_CMP: begin
        if (pos_r == POS_W'(KW_MAX_LEN - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_FETCH;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State machine outputs.
  always_comb begin
    in_ready = 1'b0;
    step     = 1'b0;
    finish   = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_FETCH: ;
      ST_CMP:   step = 1'b1;
      ST_DONE:  finish = !out_valid_r || out_chan.ready;
      default:  ;
    endcase
  end

  // One letter position against every keyword at once. A keyword that has
  // already ended stays as it is; one that needs a letter past the line drops.
  always_comb begin
    pos_in_line = (LEN_W'(pos_r) < line_len_r);
    for (int k = 0; k < KW_COUNT; k++) begin
      if (pos_r >= KW_LEN[k]) begin
        alive_nxt[k] = alive_r[k];
      end else begin
        alive_nxt[k] = alive_r[k] && pos_in_line
                       && ((8'(ram_rdata) + CHAR_A) == kw_char(k, pos_r));
      end
    end
  end

  // First surviving keyword of an enabled group wins.
  always_comb begin
    sel_code = CMD_UNKNOWN;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (alive_r[k]
          && !(KW_GROUP[k] == GRP_PAIRING && !pairing_en_r)
          && !(KW_GROUP[k] == GRP_DONGLE && !dongle_en_r)) begin
        sel_code = KW_CODE[k];
      end
    end
    if (sel_code == CMD_DEBUG) begin
      debug_nxt = 1'b1;
    end else if (sel_code == CMD_NODEBUG) begin
      debug_nxt = 1'b0;
    end else begin
      debug_nxt = debug_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      line_active_r <= 1'b0;
      line_len_r    <= '0;
      debug_r       <= 1'b0;
      pairing_en_r  <= 1'b1;
      dongle_en_r   <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IDX_PAIRING: pairing_en_r <= cfg_wdata;
          CFG_IDX_DONGLE:  dongle_en_r  <= cfg_wdata;
          default: ;
        endcase
      end

      if (in_acc) begin
        if (is_bang) begin
          line_len_r    <= '0;
          line_active_r <= 1'b1;
        end else if (is_eol) begin
          // With a command pending, the line is cleared once matching ends.
          if (!start_match) begin
            line_len_r    <= '0;
            line_active_r <= 1'b0;
          end
        end else if (line_active_r) begin
          if (is_letter) begin
            if (has_room) begin
              line_len_r <= line_len_r + 1'b1;
            end
          end else if (is_erase && line_len_r != '0) begin
            line_len_r <= line_len_r - 1'b1;
          end
        end
      end

      if (finish) begin
        line_len_r    <= '0;
        line_active_r <= 1'b0;
        debug_r       <= debug_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Match datapath and output payload.
  always_ff @(posedge clk) begin
    if (start_match) begin
      pos_r   <= '0;
      alive_r <= '1;
    end else if (step) begin
      pos_r   <= pos_r + 1'b1;
      alive_r <= alive_nxt;
    end
    if (finish) begin
      out_code_r  <= sel_code;
      out_debug_r <= debug_nxt;
    end
  end

  assign in_chan.ready          = in_ready;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.command_code  = out_code_r;
  assign out_chan.debug_enabled = out_debug_r;

endmodule

`default_nettype wire

>>> design/ccr_ram.sv
`default_nettype none

module ccr_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 31
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire
